@@ hw/rtl/mrufav_pkg.sv @@
package mrufav_pkg;

    // Field widths of the command and response transactions.
    localparam int OPC_W  = 3;
    localparam int KEY_W  = 32;
    localparam int TIME_W = 48;
    localparam int PAGE_W = 20;
    localparam int IDX_W  = 6;
    localparam int RET_W  = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_ADD     = 3'd0,
        OP_SET_FAV = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_READ    = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FRONT,
        S_READ,
        S_RESULT
    } state_t;

    // One list entry as it is kept in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] stamp;
        logic [PAGE_W-1:0] pages;
        logic              fav;
    } entry_t;

endpackage

@@ hw/rtl/mrufav_ifs.sv @@
interface mrufav_cmd_if;
    import mrufav_pkg::*;

    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic              key_valid;
    logic [KEY_W-1:0]  entry_key;
    logic [TIME_W-1:0] open_time_ms;
    logic [PAGE_W-1:0] page_total;
    logic              favorite_wanted;
    logic [IDX_W-1:0]  read_index;

    modport source (
        output valid, opcode, key_valid, entry_key, open_time_ms, page_total,
               favorite_wanted, read_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, key_valid, entry_key, open_time_ms, page_total,
               favorite_wanted, read_index,
        output ready
    );
endinterface

interface mrufav_rsp_if;
    import mrufav_pkg::*;

    logic              valid;
    logic              ready;
    logic              op_ok;
    logic [RET_W-1:0]  list_length;
    logic [KEY_W-1:0]  out_key;
    logic [TIME_W-1:0] out_time_ms;
    logic [PAGE_W-1:0] out_pages;
    logic              out_favorite;

    modport source (
        output valid, op_ok, list_length, out_key, out_time_ms, out_pages,
               out_favorite,
        input  ready
    );

    modport sink (
        input  valid, op_ok, list_length, out_key, out_time_ms, out_pages,
               out_favorite,
        output ready
    );
endinterface

@@ hw/rtl/mru_list_with_favorites.sv @@
// Most-recently-used list with favorite flags, up to CAPACITY entries.
// A command transaction on cmd (add, set favorite, remove, clear, read at index)
// produces exactly one response transaction on rsp with the status, the list
// length after the operation and, for a successful read, the entry read.
// Writing retention_limit through cfg_wr_en/cfg_wr_data trims the list at once;
// the user must write it only while the block is idle; the block does not enforce this.
// One command is in work at a time: cmd.ready is high only in the idle state.
// A clear, an unknown opcode or a refused key goes straight to the response,
// and a read passes through the read state first. Add, set favorite and
// remove first search for the key; a remove that finds it and every add then
// shift entries, and an add finally writes the new entry at the front. The
// key search and the shift each go through the entries one at a time, since the
// entry memory gives the sequencer one read and one write per cycle. The next
// command is taken in the cycle after the response is loaded.
// The response sits in an output register; if the receiver stalls, the block
// finishes the next command and then waits until the register is taken.
// Reset empties the list and clears retention_limit; the entry memory is not
// cleared, since only positions below the list length are ever read.
module mru_list_with_favorites #(
    parameter int CAPACITY = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mrufav_pkg::RET_W-1:0] cfg_wr_data,
    mrufav_cmd_if.sink                  cmd,
    mrufav_rsp_if.source                rsp
);
    import mrufav_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = (CW > RET_W) ? CW : RET_W;
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // The effective bound is retention_limit when it is nonzero and below
    // CAPACITY, otherwise CAPACITY itself.
    function automatic logic [CW-1:0] trim_len(input logic [CW-1:0] cnt,
                                               input logic [RET_W-1:0] ret);
        logic [RW-1:0] bound;
        bound = RW'(CAPACITY);
        if (ret != '0 && RW'(ret) < RW'(CAPACITY)) begin
            bound = RW'(ret);
        end
        if (RW'(cnt) > bound) begin
            return CW'(bound);
        end
        return cnt;
    endfunction

    // Control state.
    state_t              state_reg, state_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [RET_W-1:0]    ret_reg, ret_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                rsp_valid_reg, rsp_valid_next;

    // Command held during its work.
    logic [OPC_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [TIME_W-1:0]   time_reg, time_next;
    logic [PAGE_W-1:0]   pages_reg, pages_next;
    logic                fav_reg, fav_next;
    logic [IDX_W-1:0]    ridx_reg, ridx_next;

    // Sequencer datapath.
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       left_reg, left_next;
    logic                right_reg, right_next;
    logic [AW-1:0]       rd_addr_reg, rd_addr_next;
    logic                keep_reg, keep_next;
    logic                ok_reg, ok_next;

    // Response register.
    logic                rsp_ok_reg, rsp_ok_next;
    logic [CW-1:0]       rsp_len_reg, rsp_len_next;
    logic [KEY_W-1:0]    rsp_key_reg, rsp_key_next;
    logic [TIME_W-1:0]   rsp_time_reg, rsp_time_next;
    logic [PAGE_W-1:0]   rsp_pages_reg, rsp_pages_next;
    logic                rsp_fav_reg, rsp_fav_next;

    // Entry memory: one write and one registered read per cycle.
    entry_t              mem [CAPACITY];
    entry_t              mem_q;
    entry_t              wd;
    logic                mem_we;
    logic                mem_re;
    logic [AW-1:0]       wa;
    logic [AW-1:0]       ra;

    // Shared compare and bookkeeping terms.
    logic                hit;
    logic                scan_more;
    logic [CW-1:0]       hit_pos;
    logic [CW-1:0]       add_base;
    logic                ridx_ok;
    logic [CW-1:0]       trimmed;
    logic                rsp_load;

    assign hit       = rd_pend_reg && (mem_q.key == key_reg);
    assign scan_more = ptr_reg < used_reg;
    assign hit_pos   = CW'(rd_addr_reg);
    assign add_base  = (used_reg == CAP_CNT) ? CAP_CNT - CW'(1) : used_reg;
    assign ridx_ok   = XW'(ridx_reg) < XW'(used_reg);
    assign trimmed   = trim_len(used_reg, ret_reg);
    assign rsp_load  = !rsp_valid_reg || rsp.ready;

    assign cmd.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.op_ok        = rsp_ok_reg;
    assign rsp.list_length  = RET_W'(rsp_len_reg);
    assign rsp.out_key      = rsp_key_reg;
    assign rsp.out_time_ms  = rsp_time_reg;
    assign rsp.out_pages    = rsp_pages_reg;
    assign rsp.out_favorite = rsp_fav_reg;

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid) begin
                    case (cmd.opcode)
                        OP_ADD, OP_SET_FAV, OP_REMOVE:
                            state_next = cmd.key_valid ? S_SEARCH : S_RESULT;
                        OP_READ:
                            state_next = S_READ;
                        default:
                            state_next = S_RESULT;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (hit) begin
                    state_next = (op_reg == OP_SET_FAV) ? S_RESULT : S_SHIFT;
                end else if (!scan_more) begin
                    state_next = (op_reg == OP_ADD) ? S_SHIFT : S_RESULT;
                end
            end
            S_SHIFT:
            begin
                if (left_reg == '0) begin
                    state_next = (op_reg == OP_ADD) ? S_FRONT : S_RESULT;
                end
            end
            S_FRONT:
                state_next = S_RESULT;
            S_READ:
                state_next = S_RESULT;
            S_RESULT:
            begin
                if (rsp_load) begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory control of the sequencer.
    always_comb
    begin
        used_next      = used_reg;
        ret_next       = ret_reg;
        rsp_valid_next = rsp_valid_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        time_next      = time_reg;
        pages_next     = pages_reg;
        fav_next       = fav_reg;
        ridx_next      = ridx_reg;
        ptr_next       = ptr_reg;
        left_next      = left_reg;
        right_next     = right_reg;
        keep_next      = keep_reg;
        ok_next        = ok_reg;
        rsp_ok_next    = rsp_ok_reg;
        rsp_len_next   = rsp_len_reg;
        rsp_key_next   = rsp_key_reg;
        rsp_time_next  = rsp_time_reg;
        rsp_pages_next = rsp_pages_reg;
        rsp_fav_next   = rsp_fav_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        wa             = '0;
        ra             = '0;
        wd             = mem_q;

        if (rsp_valid_reg && rsp.ready) begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid) begin
                    op_next    = cmd.opcode;
                    key_next   = cmd.entry_key;
                    time_next  = cmd.open_time_ms;
                    pages_next = cmd.page_total;
                    fav_next   = cmd.favorite_wanted;
                    ridx_next  = cmd.read_index;
                    ptr_next   = '0;
                    keep_next  = 1'b0;
                    ok_next    = 1'b0;
                    if (cmd.opcode == OP_CLEAR) begin
                        used_next = '0;
                        ok_next   = 1'b1;
                    end
                end
            end
            S_SEARCH:
            begin
                if (hit) begin
                    case (op_reg)
                        OP_SET_FAV:
                        begin
                            // Only a real change of the flag counts.
                            if (mem_q.fav != fav_reg) begin
                                mem_we = 1'b1;
                                wa     = rd_addr_reg;
                                wd.fav = fav_reg;
                                ok_next = 1'b1;
                            end
                        end
                        OP_ADD:
                        begin
                            // Entries ahead of the old copy move back one place.
                            keep_next  = mem_q.fav;
                            ptr_next   = hit_pos - CW'(1);
                            left_next  = hit_pos;
                            right_next = 1'b1;
                            ok_next    = 1'b1;
                        end
                        default:
                        begin
                            // Remove: entries behind the hit move forward.
                            ptr_next   = hit_pos + CW'(1);
                            left_next  = used_reg - hit_pos - CW'(1);
                            right_next = 1'b0;
                            used_next  = used_reg - CW'(1);
                            ok_next    = 1'b1;
                        end
                    endcase
                end else if (scan_more) begin
                    mem_re   = 1'b1;
                    ra       = ptr_reg[AW-1:0];
                    ptr_next = ptr_reg + CW'(1);
                end else if (op_reg == OP_ADD) begin
                    // New key: a full list drops its oldest entry.
                    ptr_next   = add_base - CW'(1);
                    left_next  = add_base;
                    right_next = 1'b1;
                    used_next  = add_base + CW'(1);
                    ok_next    = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (rd_pend_reg) begin
                    mem_we = 1'b1;
                    wa     = right_reg ? rd_addr_reg + AW'(1) : rd_addr_reg - AW'(1);
                end
                if (left_reg != '0) begin
                    mem_re    = 1'b1;
                    ra        = ptr_reg[AW-1:0];
                    ptr_next  = right_reg ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
                    left_next = left_reg - CW'(1);
                end
            end
            S_FRONT:
            begin
                mem_we   = 1'b1;
                wa       = '0;
                wd.key   = key_reg;
                wd.stamp = time_reg;
                wd.pages = pages_reg;
                wd.fav   = keep_reg;
            end
            S_READ:
            begin
                if (ridx_ok) begin
                    mem_re  = 1'b1;
                    ra      = AW'(ridx_reg);
                    ok_next = 1'b1;
                end
            end
            S_RESULT:
            begin
                if (rsp_load) begin
                    rsp_valid_next = 1'b1;
                    rsp_ok_next    = ok_reg;
                    rsp_len_next   = trimmed;
                    used_next      = trimmed;
                    if (op_reg == OP_READ && ok_reg) begin
                        rsp_key_next   = mem_q.key;
                        rsp_time_next  = mem_q.stamp;
                        rsp_pages_next = mem_q.pages;
                        rsp_fav_next   = mem_q.fav;
                    end else begin
                        rsp_key_next   = '0;
                        rsp_time_next  = '0;
                        rsp_pages_next = '0;
                        rsp_fav_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // A register write trims the list right away.
        if (cfg_wr_en) begin
            ret_next  = cfg_wr_data;
            used_next = trim_len(used_reg, cfg_wr_data);
        end
    end

    assign rd_pend_next = mem_re;
    assign rd_addr_next = ra;

    always_ff @(posedge clk)
    begin
        if (mem_we) begin
            mem[wa] <= wd;
        end
        if (mem_re) begin
            mem_q <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            ret_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            ret_reg       <= ret_next;
            rd_pend_reg   <= rd_pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        time_reg      <= time_next;
        pages_reg     <= pages_next;
        fav_reg       <= fav_next;
        ridx_reg      <= ridx_next;
        ptr_reg       <= ptr_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        rd_addr_reg   <= rd_addr_next;
        keep_reg      <= keep_next;
        ok_reg        <= ok_next;
        rsp_ok_reg    <= rsp_ok_next;
        rsp_len_reg   <= rsp_len_next;
        rsp_key_reg   <= rsp_key_next;
        rsp_time_reg  <= rsp_time_next;
        rsp_pages_reg <= rsp_pages_next;
        rsp_fav_reg   <= rsp_fav_next;
    end

endmodule
